FILE: design/sjfs_pkg.sv
// Shared types and constants for the shortest-job-first scheduler.
// Used by sjfs_ctrl, sjfs_dp and the top level; depends on nothing.
package sjfs_pkg;

  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int CNT_W   = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Result kinds carried on the output tuser
  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_RUN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  // One job table entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] rem;
    logic [CNT_W-1:0]   wt;
    logic [CNT_W-1:0]   ta;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR,
    S_SCAN,
    S_PICK,
    S_SEL,
    S_UPD,
    S_TAIL,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic idx_clr;
    logic idx_inc;
    logic arr_step;
    logic scan_rd;
    logic upd_rd;
    logic sel;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_tick;
    logic idx_last;
    logic slot_free;
    logic sel_found;
    logic out_free;
  } stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

FILE: design/sjfs_ctrl.sv
// Sequencer for the scheduler: steps arrivals, table scans and updates.
// Depends on sjfs_pkg; drives the datapath through cmd_t, reads stat_t.
module sjfs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            in_ready,
  input  sjfs_pkg::stat_t st,
  output sjfs_pkg::cmd_t  cmd
);
  import sjfs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = st.in_tick ? S_SCAN : S_ARR;
        end
      end
      S_ARR: begin
        cmd.arr_step = 1'b1;
        if (st.slot_free || st.idx_last) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_PICK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PICK: begin
        // last compare of the scan lands here
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = st.sel_found ? S_UPD : S_DONE;
      end
      S_UPD: begin
        cmd.upd_rd = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_TAIL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TAIL: begin
        // last write-back of the update pass lands here
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/sjfs_dp.sv
// Datapath of the scheduler: job table memory, valid bits, min tracker,
// per-slot counter update and the output register. Depends on sjfs_pkg.
module sjfs_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [23:0]                  s_tdata,
  input  logic [0:0]                   s_tuser,
  input  logic                         cfg_valid,
  input  logic [0:0]                   cfg_data,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [55:0]                  m_tdata,
  output logic [2:0]                   m_tuser,
  input  sjfs_pkg::cmd_t               cmd,
  output sjfs_pkg::stat_t              st
);
  import sjfs_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);

  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_data;
  logic [TABLE_DEPTH-1:0] valid;
  logic [IW-1:0]       idx, pipe_idx, best_slot, cur_slot, sel_slot, sel_slot_c, wr_addr;
  logic                scan_pipe, upd_pipe, best_found, cur_active, mode;
  logic [BURST_W-1:0]  best_rem, in_burst;
  logic [ID_W-1:0]     in_id, res_id;
  status_t             res_status;
  logic                res_fin;
  logic [CNT_W-1:0]    res_wait, res_turn;
  logic                wr_en, sel_keep, sel_found_c, upd_hit, upd_done, upd_live, better;
  entry_t              wr_data, upd_entry;

  always_comb begin
    sel_keep    = !mode && cur_active && valid[cur_slot];
    sel_slot_c  = sel_keep ? cur_slot : best_slot;
    sel_found_c = sel_keep || best_found;

    better   = scan_pipe && valid[pipe_idx] && (!best_found || (rd_data.rem < best_rem));
    upd_live = upd_pipe && valid[pipe_idx];
    upd_hit  = (pipe_idx == sel_slot);

    upd_entry.id  = rd_data.id;
    upd_entry.rem = (upd_hit && (rd_data.rem != '0)) ? rd_data.rem - 1'b1 : rd_data.rem;
    upd_entry.wt  = upd_hit ? rd_data.wt : sat_inc(rd_data.wt);
    upd_entry.ta  = sat_inc(rd_data.ta);
    upd_done      = upd_hit && (upd_entry.rem == '0);

    wr_en   = 1'b0;
    wr_addr = pipe_idx;
    wr_data = upd_entry;
    if (cmd.arr_step && !valid[idx]) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data = '{id: in_id, rem: in_burst, wt: '0, ta: '0};
    end else if (upd_live) begin
      wr_en = 1'b1;
    end

    st.in_tick   = s_tuser[0];
    st.idx_last  = (idx == IDX_LAST);
    st.slot_free = !valid[idx];
    st.sel_found = sel_found_c;
    st.out_free  = !m_tvalid || m_tready;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b1;
      valid      <= '0;
      cur_active <= 1'b0;
      cur_slot   <= '0;
      scan_pipe  <= 1'b0;
      upd_pipe   <= 1'b0;
      best_found <= 1'b0;
      m_tvalid   <= 1'b0;
      idx        <= '0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data[0];
      end
      scan_pipe <= cmd.scan_rd;
      upd_pipe  <= cmd.upd_rd;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.load_in) begin
        best_found <= 1'b0;
      end else if (better) begin
        best_found <= 1'b1;
      end
      if (cmd.arr_step && !valid[idx]) begin
        valid[idx] <= 1'b1;
      end
      if (cmd.sel && !sel_found_c) begin
        cur_active <= 1'b0;
      end
      if (upd_live && upd_hit) begin
        if (upd_done) begin
          valid[pipe_idx] <= 1'b0;
          cur_active      <= 1'b0;
        end else begin
          cur_slot   <= pipe_idx;
          cur_active <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= idx;
    if (better) begin
      best_rem  <= rd_data.rem;
      best_slot <= pipe_idx;
    end
    if (cmd.load_in) begin
      in_id      <= s_tdata[7:0];
      in_burst   <= s_tdata[23:8];
      res_status <= ST_ACCEPT;
      res_id     <= '0;
      res_fin    <= 1'b0;
      res_wait   <= '0;
      res_turn   <= '0;
    end
    if (cmd.arr_step) begin
      res_status <= valid[idx] ? ST_FULL : ST_ACCEPT;
    end
    if (cmd.sel) begin
      sel_slot   <= sel_slot_c;
      res_status <= sel_found_c ? ST_RUN : ST_IDLE;
    end
    if (upd_live && upd_hit) begin
      res_id <= rd_data.id;
      if (upd_done) begin
        res_fin  <= 1'b1;
        res_wait <= upd_entry.wt;
        res_turn <= upd_entry.ta;
      end
    end
    if (cmd.out_load) begin
      m_tdata <= {res_turn, res_wait, res_id};
      m_tuser <= {res_fin, res_status};
    end
  end

  a_cur_valid: assert property (@(posedge clk) disable iff (rst)
    cur_active |-> valid[cur_slot])
    else $error("running slot is not marked valid");

  a_fin_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == ST_RUN))
    else $error("finish reported on a word that is not a served tick");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1:0] != ST_RUN)) |-> (m_tdata == '0) && !m_tuser[2])
    else $error("non-run word carries job data");

  a_turn_gt_wait: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |->
      ((m_tdata[55:32] > m_tdata[31:8]) || (m_tdata[55:32] == CNT_MAX)))
    else $error("turnaround not above wait for finished job");

endmodule

FILE: design/shortest_job_first_scheduler.sv
// Top level of the shortest-remaining-time-first job scheduler.
// Depends on sjfs_pkg, sjfs_ctrl and sjfs_dp.
//
// Each input word is either a job arrival (id, burst length) or one time tick,
// and each produces exactly one output word. The job table of TABLE_DEPTH slots
// lives in a single-port-write, registered-read memory and is walked one slot
// per cycle, so timing is set by that memory port: an arrival searches for the
// lowest free slot and then posts its result; a tick runs a scan for the least
// remaining time, a select state, then a read-modify-write pass that bumps the
// turnaround counter of every pending job and the wait counter of every pending
// job except the one that is served, and after that posts its result.
// An idle tick skips the update pass. One item is worked at a time; the next
// word is taken as soon as the previous result has moved into the output
// register, even while that register still waits for m_tready. Ties on
// remaining time go to the lowest slot. preemptive_mode (cfg_data, reset 1)
// reselects the shortest job every tick; 0 lets the running job finish first.
// Write it only while the block is idle. No clearing pass follows reset.
module shortest_job_first_scheduler #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] job_id, [23:8] burst_length
  input  logic [0:0]  s_tuser,   // [0] req_type (0 arrival, 1 tick)
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] running_id, [31:8] finish_wait,
                                 // [55:32] finish_turnaround
  output logic [2:0]  m_tuser,   // [1:0] status_code, [2] finish_valid
  // Mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data   // [0] preemptive_mode
);
  import sjfs_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // The mode register takes a write in any cycle
  assign cfg_ready = 1'b1;

  sjfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sjfs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: test/tb_shortest_job_first_scheduler.sv
// Self-checking bench for shortest_job_first_scheduler: a stream driver, a stream
// monitor with an SRTF job-table predictor, and mode register writes between phases.
// Depends on sjfs_pkg and the scheduler RTL.
module tb_shortest_job_first_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import sjfs_pkg::*;

  localparam int DEPTH     = 16;
  localparam int CYC_LIMIT = 400000;
  localparam int SETTLE    = 2 * DEPTH + 8;

  // One request word as the sender sees it
  typedef struct {
    bit                 tick;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
  } req_t;

  // One result word as the predictor expects it
  typedef struct {
    status_t            st;
    logic [ID_W-1:0]    rid;
    bit                 fin;
    logic [CNT_W-1:0]   fwait;
    logic [CNT_W-1:0]   fturn;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;

  shortest_job_first_scheduler #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the job table, the running-job pointer and mode
  // ---------------------------------------------------------------------------
  bit                 job_on   [DEPTH];
  logic [ID_W-1:0]    job_id   [DEPTH];
  logic [BURST_W-1:0] job_left [DEPTH];
  logic [CNT_W-1:0]   job_wait [DEPTH];
  logic [CNT_W-1:0]   job_turn [DEPTH];
  int                 run_slot = 0;
  bit                 run_live = 1'b0;
  bit                 preempt  = 1'b1;

  req_t     req_q[$];       // words waiting for the driver
  outcome_t outcome_q[$];   // results owed by the block, oldest first

  int  errs   = 0;
  int  cycles = 0;
  bit  quiet  = 1'b0;       // suppress idling on both sides
  bit  in_fire  = 1'b0;
  bit  out_fire = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_next;

  function automatic logic [CNT_W-1:0] bump_sat(logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Apply one accepted word to the table and return the result it owes
  function automatic outcome_t sched_step(req_t r);
    outcome_t o;
    int pick;
    o.st    = ST_ACCEPT;
    o.rid   = '0;
    o.fin   = 1'b0;
    o.fwait = '0;
    o.fturn = '0;
    if (!r.tick) begin
      // Arrival: lowest free slot, or drop when the table is full
      for (int k = 0; k < DEPTH; k++) begin
        if (!job_on[k]) begin
          job_on[k]   = 1'b1;
          job_id[k]   = r.id;
          job_left[k] = r.burst;
          job_wait[k] = '0;
          job_turn[k] = '0;
          return o;
        end
      end
      o.st = ST_FULL;
      return o;
    end
    // Tick: keep the running job in non-preemptive mode, else least remaining
    pick = -1;
    if (!preempt && run_live && job_on[run_slot]) begin
      pick = run_slot;
    end else begin
      for (int k = 0; k < DEPTH; k++)
        if (job_on[k] && (pick < 0 || job_left[k] < job_left[pick])) pick = k;
    end
    if (pick < 0) begin
      run_live = 1'b0;
      o.st = ST_IDLE;
      return o;
    end
    if (job_left[pick] != 0) job_left[pick] = job_left[pick] - 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      if (job_on[k]) begin
        if (k != pick) job_wait[k] = bump_sat(job_wait[k]);
        job_turn[k] = bump_sat(job_turn[k]);
      end
    end
    o.st  = ST_RUN;
    o.rid = job_id[pick];
    if (job_left[pick] == 0) begin
      o.fin       = 1'b1;
      o.fwait     = job_wait[pick];
      o.fturn     = job_turn[pick];
      job_on[pick] = 1'b0;
      run_live    = 1'b0;
    end else begin
      run_slot = pick;
      run_live = 1'b1;
    end
    return o;
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic flag(string what, longint got, longint want);
    $display("MISMATCH %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want, cycles);
    errs++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one word at a time, with an idle gap from draw_gap() after each word
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else if (!s_tvalid || in_fire) begin
      if (tx_gap > 0) begin
        // hold off before the next word
        s_tvalid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (req_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {req_q[0].burst, req_q[0].id};
        s_tuser  <= req_q[0].tick;
        tx_gap   <= draw_gap();
        void'(req_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: drop ready for a gap from draw_gap() ahead of each result word
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= draw_gap();
    end else begin
      rx_next = out_fire ? draw_gap() : rx_gap;
      if (rx_next > 0) begin
        m_tready <= 1'b0;
        rx_gap   <= rx_next - 1;
      end else begin
        m_tready <= 1'b1;
        rx_gap   <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= s_tvalid && s_tready;
      out_fire <= m_tvalid && m_tready;
      if (cfg_valid && cfg_ready) preempt = cfg_data[0];
      if (s_tvalid && s_tready)
        outcome_q.push_back(sched_step('{s_tuser[0], s_tdata[7:0], s_tdata[23:8]}));
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          flag("unexpected result word", {m_tuser, m_tdata}, 0);
        end else begin
          if (m_tuser[1:0] != outcome_q[0].st)    flag("status", m_tuser[1:0], outcome_q[0].st);
          if (m_tuser[2] != outcome_q[0].fin)     flag("finish", m_tuser[2], outcome_q[0].fin);
          if (m_tdata[7:0] != outcome_q[0].rid)
            flag("running id", m_tdata[7:0], outcome_q[0].rid);
          if (m_tdata[31:8] != outcome_q[0].fwait)
            flag("finish wait", m_tdata[31:8], outcome_q[0].fwait);
          if (m_tdata[55:32] != outcome_q[0].fturn)
            flag("turnaround", m_tdata[55:32], outcome_q[0].fturn);
          void'(outcome_q.pop_front());
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_job(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
    req_q.push_back('{1'b0, id, burst});
  endtask

  task automatic add_tick();
    // id and burst are don't-care on a tick; fill them with noise
    req_q.push_back('{1'b1, ID_W'($urandom), BURST_W'($urandom)});
  endtask

  // Random mix: tick_pct percent ticks, short bursts, rare long or zero bursts
  task automatic add_mix(int n, int tick_pct, int max_burst, int big_pct);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < tick_pct) begin
        add_tick();
      end else if ($urandom_range(0, 99) < big_pct) begin
        add_job(ID_W'($urandom), BURST_W'($urandom_range(1, 65535)));
      end else if ($urandom_range(0, 99) == 0) begin
        add_job(ID_W'($urandom), '0);
      end else begin
        add_job(ID_W'($urandom), BURST_W'($urandom_range(1, max_burst)));
      end
    end
  endtask

  // Hold the sender until every owed result is back, then let the block settle
  task automatic drain();
    while (req_q.size() > 0 || s_tvalid || outcome_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the mode register while the block is idle
  task automatic set_mode(bit v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      job_on[k]   = 1'b0;
      job_id[k]   = '0;
      job_left[k] = '0;
      job_wait[k] = '0;
      job_turn[k] = '0;
    end
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset mode (preemptive)
    add_tick();                   // idle tick on an empty table
    add_job(8'h00, 16'd0);        // zero burst: done on its first tick
    add_tick();
    add_job(8'hFF, 16'd3);        // duplicate ids with equal bursts: lowest slot wins
    add_job(8'hFF, 16'd3);
    add_tick();
    add_job(8'h5A, 16'd1);        // arrival mid-run preempts on the next tick
    add_tick();
    for (int k = 0; k < DEPTH - 2; k++) add_job(ID_W'(8'h10 + k), 16'd2);
    add_job(8'hAA, 16'd1);        // table full: dropped
    add_tick();
    add_tick();

    // Non-preemptive with jobs still pending: the last served job keeps the unit
    set_mode(1'b0);
    add_mix(200, 65, 4, 0);

    // Back to preemptive, no idling on either side
    set_mode(1'b1);
    quiet = 1'b1;
    add_mix(120, 70, 6, 0);
    drain();
    quiet = 1'b0;

    set_mode(1'b0);
    add_mix(150, 75, 8, 0);

    // Preemptive with the longest bursts mixed in
    set_mode(1'b1);
    add_job(8'h3C, 16'hFFFF);
    add_mix(200, 70, 4, 4);

    drain();
    if (errs == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
